>>> rtl/core/cbfw_pkg.sv
// Package of the checkerboard box-filter weight block: widths, constants,
// sideband type. No dependencies.
`default_nettype none
package cbfw_pkg;
	localparam int FRAC_BITS = 16;
	localparam int CW        = 32;              // coordinate / derivative width
	localparam int SPW       = 17;              // split register width, Q1.16
	localparam int WW        = 17;              // weight width
	localparam int DW        = CW - 1;          // magnitude width
	localparam int SUW       = FRAC_BITS + 1;   // scaled split width
	localparam int S2W       = FRAC_BITS + 2;   // doubled split width
	localparam int XW        = CW + 1;          // half-LSB box edge width
	localparam int CLW       = XW - FRAC_BITS - 1; // cell index width
	localparam int LW        = CW;              // covered length width
	localparam int PW        = 2 * LW;          // product / numerator width
	localparam int QB        = 16;              // quotient bits
	localparam int IDXW      = 2;

	localparam logic [IDXW-1:0] REG_SPLIT_U = 2'd0;
	localparam logic [IDXW-1:0] REG_SPLIT_V = 2'd1;
	localparam logic [IDXW-1:0] REG_AA_MODE = 2'd2;

	localparam logic [WW-1:0] W_ONE = WW'(1 << 16);

	typedef struct packed {
		logic full;
		logic pt;
		logic in_a;
	} cbfw_side_t;

	function automatic logic [SUW-1:0] split_scaled(input logic [SPW-1:0] s);
		logic [SPW-1:0] c;
		c = (s > SPW'(1 << 16)) ? SPW'(1 << 16) : s;
		if (FRAC_BITS >= 16)
			return SUW'({8'd0, c} << (FRAC_BITS - 16));
		else
			return SUW'(c >> (16 - FRAC_BITS));
	endfunction

	function automatic logic [DW-1:0] sat_abs(input logic [CW-1:0] x);
		logic [CW-1:0] n;
		n = -x;
		if (!x[CW-1])
			return x[DW-1:0];
		else if (n[CW-1])
			return {DW{1'b1}};
		else
			return n[DW-1:0];
	endfunction
endpackage
`default_nettype wire

>>> rtl/core/cbfw_if.sv
// Request and result channel interfaces of the checkerboard weight block.
// Depends on cbfw_pkg.
`default_nettype none
interface cbfw_sample_if;
	logic                    valid;
	logic                    ready;
	logic [cbfw_pkg::CW-1:0] coord_u;
	logic [cbfw_pkg::CW-1:0] coord_v;
	logic [cbfw_pkg::CW-1:0] du_di;
	logic [cbfw_pkg::CW-1:0] dv_di;
	logic [cbfw_pkg::CW-1:0] du_dj;
	logic [cbfw_pkg::CW-1:0] dv_dj;
	modport source (output valid, coord_u, coord_v, du_di, dv_di, du_dj, dv_dj,
		input ready);
	modport sink (input valid, coord_u, coord_v, du_di, dv_di, du_dj, dv_dj,
		output ready);
endinterface

interface cbfw_result_if;
	logic                    valid;
	logic                    ready;
	logic [cbfw_pkg::WW-1:0] weight_a;
	logic                    point_sampled;
	modport source (output valid, weight_a, point_sampled, input ready);
	modport sink (input valid, weight_a, point_sampled, output ready);
endinterface
`default_nettype wire

>>> rtl/core/checker_box_filter_weight.sv
// Checkerboard box-filter weight: footprint, covered lengths, area ratio.
// Depends on cbfw_pkg, cbfw_if, cbfw_divider.
// Pipeline of 5 arithmetic stages and 16 divider stages, one request
// per cycle sustained; the whole pipeline halts while the result is stalled.
// Reset clears the valid bits and sets split_u = split_v = 0.5, box mode on.
`default_nettype none
module checker_box_filter_weight (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	cbfw_sample_if.sink                    sample,
	cbfw_result_if.source                  result,
	input  wire logic                      cfg_wen,
	input  wire logic [cbfw_pkg::IDXW-1:0] cfg_idx,
	input  wire logic [cbfw_pkg::SPW-1:0]  cfg_wdata
);
	import cbfw_pkg::*;

	logic [SPW-1:0] split_u_q, split_v_q;
	logic           aa_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			split_u_q <= SPW'(32768);
			split_v_q <= SPW'(32768);
			aa_mode_q <= 1'b1;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				REG_SPLIT_U: split_u_q <= cfg_wdata;
				REG_SPLIT_V: split_v_q <= cfg_wdata;
				REG_AA_MODE: aa_mode_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	logic [SUW-1:0] su, sv;
	logic [S2W-1:0] su2, sv2;
	assign su  = split_scaled(split_u_q);
	assign sv  = split_scaled(split_v_q);
	assign su2 = {su, 1'b0};
	assign sv2 = {sv, 1'b0};

	logic en;
	logic div_valid;
	assign en           = !div_valid || result.ready;
	assign sample.ready = en;

	// stage 1: footprint and point test
	logic [DW-1:0] adu_i, adu_j, adv_i, adv_j;
	logic [FRAC_BITS-1:0] fu, fv;
	assign adu_i = sat_abs(sample.du_di);
	assign adu_j = sat_abs(sample.du_dj);
	assign adv_i = sat_abs(sample.dv_di);
	assign adv_j = sat_abs(sample.dv_dj);
	assign fu    = sample.coord_u[FRAC_BITS-1:0];
	assign fv    = sample.coord_v[FRAC_BITS-1:0];

	logic                 v_s1;
	logic [DW-1:0]        du_s1, dv_s1;
	logic [FRAC_BITS-1:0] fu_s1, fv_s1;
	cbfw_side_t           side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= sample.valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			du_s1        <= (adu_j > adu_i) ? adu_j : adu_i;
			dv_s1        <= (adv_j > adv_i) ? adv_j : adv_i;
			fu_s1        <= fu;
			fv_s1        <= fv;
			side_s1.full <= 1'b0;
			side_s1.pt   <= !aa_mode_q || (adu_i == '0 && adu_j == '0)
				|| (adv_i == '0 && adv_j == '0);
			side_s1.in_a <= ((SUW'(fu) < su) == (SUW'(fv) < sv));
		end
	end

	// stage 2: box edges in half-LSB units, cell span and partial cover
	logic signed [XW-1:0] uhi, ulo, vhi, vlo;
	assign uhi = $signed(XW'({fu_s1, 1'b0})) + $signed(XW'(du_s1));
	assign ulo = $signed(XW'({fu_s1, 1'b0})) - $signed(XW'(du_s1));
	assign vhi = $signed(XW'({fv_s1, 1'b0})) + $signed(XW'(dv_s1));
	assign vlo = $signed(XW'({fv_s1, 1'b0})) - $signed(XW'(dv_s1));

	function automatic logic [S2W-1:0] fr_cover(input logic [XW-1:0] x,
		input logic [S2W-1:0] s2);
		logic [S2W-1:0] fr;
		fr = S2W'(x[FRAC_BITS:0]);
		return (fr < s2) ? fr : s2;
	endfunction

	logic                 v_s2;
	logic [CLW-1:0]       ucell_s2, vcell_s2;
	logic [S2W-1:0]       uch_s2, ucl_s2, vch_s2, vcl_s2;
	logic [DW-1:0]        du_s2, dv_s2;
	cbfw_side_t           side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ucell_s2 <= CLW'(uhi[XW-1:FRAC_BITS+1]) - CLW'(ulo[XW-1:FRAC_BITS+1]);
			vcell_s2 <= CLW'(vhi[XW-1:FRAC_BITS+1]) - CLW'(vlo[XW-1:FRAC_BITS+1]);
			uch_s2   <= fr_cover(uhi, su2);
			ucl_s2   <= fr_cover(ulo, su2);
			vch_s2   <= fr_cover(vhi, sv2);
			vcl_s2   <= fr_cover(vlo, sv2);
			du_s2    <= du_s1;
			dv_s2    <= dv_s1;
			side_s2  <= side_s1;
		end
	end

	// stage 3: covered low lengths, footprint product
	logic [LW+S2W-1:0] lu_w, lv_w;
	assign lu_w = (LW+S2W)'(ucell_s2) * (LW+S2W)'(su2)
		+ (LW+S2W)'(uch_s2) - (LW+S2W)'(ucl_s2);
	assign lv_w = (LW+S2W)'(vcell_s2) * (LW+S2W)'(sv2)
		+ (LW+S2W)'(vch_s2) - (LW+S2W)'(vcl_s2);

	logic             v_s3;
	logic [LW-1:0]    lu_s3, lv_s3, wu_s3, wv_s3;
	logic [2*DW-1:0]  dd_s3;
	cbfw_side_t       side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (en)
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lu_s3   <= lu_w[LW-1:0];
			lv_s3   <= lv_w[LW-1:0];
			wu_s3   <= {du_s2, 1'b0};
			wv_s3   <= {dv_s2, 1'b0};
			dd_s3   <= (2*DW)'(du_s2) * (2*DW)'(dv_s2);
			side_s3 <= side_s2;
		end
	end

	// stage 4: area products
	logic [LW-1:0] hu, hv;
	assign hu = wu_s3 - lu_s3;
	assign hv = wv_s3 - lv_s3;

	logic          v_s4;
	logic [PW-1:0] pl_s4, ph_s4, den_s4;
	cbfw_side_t    side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else if (en)
			v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s4   <= PW'(lu_s3) * PW'(lv_s3);
			ph_s4   <= PW'(hu) * PW'(hv);
			den_s4  <= {dd_s3, 2'b00};
			side_s4 <= side_s3;
		end
	end

	// stage 5: numerator and full-area check
	logic [PW-1:0] num;
	assign num = pl_s4 + ph_s4;

	logic          v_s5;
	logic [PW-1:0] num_s5, den_s5;
	cbfw_side_t    side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s5 <= 1'b0;
		else if (en)
			v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s5       <= den_s4;
			side_s5.pt   <= side_s4.pt;
			side_s5.in_a <= side_s4.in_a;
			side_s5.full <= (num >= den_s4);
			num_s5       <= (num >= den_s4) ? '0 : num;
		end
	end

	logic [QB-1:0] quot;
	cbfw_side_t    side_out;

	cbfw_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (v_s5),
		.num       (num_s5),
		.den       (den_s5),
		.side_in   (side_s5),
		.valid_out (div_valid),
		.quot      (quot),
		.side_out  (side_out)
	);

	assign result.valid         = div_valid;
	assign result.point_sampled = side_out.pt;
	assign result.weight_a      = side_out.pt ? (side_out.in_a ? W_ONE : '0)
		: (side_out.full ? W_ONE : {1'b0, quot});
endmodule
`default_nettype wire

>>> rtl/core/cbfw_divider.sv
// Pipelined restoring divider, one quotient bit per stage, for num < den.
// Depends on cbfw_pkg.
`default_nettype none
module cbfw_divider (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     en,
	input  wire logic                     valid_in,
	input  wire logic [cbfw_pkg::PW-1:0]  num,
	input  wire logic [cbfw_pkg::PW-1:0]  den,
	input  wire cbfw_pkg::cbfw_side_t     side_in,
	output logic                          valid_out,
	output logic [cbfw_pkg::QB-1:0]       quot,
	output cbfw_pkg::cbfw_side_t          side_out
);
	import cbfw_pkg::*;

	logic             v_q [QB+1];
	logic [PW-1:0]    r_q [QB+1];
	logic [PW-1:0]    d_q [QB+1];
	logic [QB-1:0]    q_q [QB+1];
	cbfw_side_t       s_q [QB+1];

	always_comb begin
		v_q[0] = valid_in;
		r_q[0] = num;
		d_q[0] = den;
		q_q[0] = '0;
		s_q[0] = side_in;
	end

	for (genvar k = 0; k < QB; k++) begin : g_stage
		logic [PW:0] r2;
		assign r2 = {r_q[k], 1'b0};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_q[k+1] <= 1'b0;
			else if (en)
				v_q[k+1] <= v_q[k];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				d_q[k+1] <= d_q[k];
				s_q[k+1] <= s_q[k];
				if (r2 >= {1'b0, d_q[k]}) begin
					r_q[k+1] <= PW'(r2 - {1'b0, d_q[k]});
					q_q[k+1] <= {q_q[k][QB-2:0], 1'b1};
				end else begin
					r_q[k+1] <= r2[PW-1:0];
					q_q[k+1] <= {q_q[k][QB-2:0], 1'b0};
				end
			end
		end
	end

	assign valid_out = v_q[QB];
	assign quot      = q_q[QB];
	assign side_out  = s_q[QB];
endmodule
`default_nettype wire

>>> bench/tb_checker_box_filter_weight.sv
// Bench for checker_box_filter_weight: random and directed requests, a
// predicted weight queue and a result checker. Depends on cbfw_pkg, cbfw_if
// and the block itself.
`default_nettype none
module tb_checker_box_filter_weight;
	import cbfw_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN       = 40;

	typedef struct packed {
		logic [CW-1:0] coord_u;
		logic [CW-1:0] coord_v;
		logic [CW-1:0] du_di;
		logic [CW-1:0] dv_di;
		logic [CW-1:0] du_dj;
		logic [CW-1:0] dv_dj;
	} request_t;

	typedef struct packed {
		logic [WW-1:0] weight_a;
		logic          point_sampled;
	} weight_t;

	logic clk;
	logic arst_n;
	logic cfg_wen;
	logic [IDXW-1:0] cfg_idx;
	logic [SPW-1:0] cfg_wdata;

	cbfw_sample_if sample ();
	cbfw_result_if result ();

	checker_box_filter_weight uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample   (sample.sink),
		.result   (result.source),
		.cfg_wen  (cfg_wen),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	logic [SPW-1:0] split_u_q;
	logic [SPW-1:0] split_v_q;
	logic           box_mode_q;

	weight_t pending_weights[$];
	int      mismatches;
	int      cycles;
	bit      quiet;
	bit      long_hold;

	initial clk = 1'b0;

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("checker_box_filter_weight regression: fail");
			$finish;
		end
	end

	function automatic longint magnitude(input logic [CW-1:0] x);
		longint s;
		s = longint'(signed'(x));
		if (s < 0)
			s = -s;
		if (s > 64'sh7FFFFFFF)
			s = 64'sh7FFFFFFF;
		return s;
	endfunction

	// length of [0,x) inside the low part [0,s2) of each cell, half-LSB units
	function automatic longint low_span(input longint x, input longint s2);
		longint fr;
		fr = x & ((longint'(1) << (FRAC_BITS + 1)) - 1);
		return (x >>> (FRAC_BITS + 1)) * s2 + ((fr < s2) ? fr : s2);
	endfunction

	function automatic weight_t checker_weight(input request_t rq);
		weight_t w;
		longint su, sv, du, dv, a, cu2, cv2, lu, lv, hu, hv;
		logic [63:0] num, den, r;
		logic [WW-1:0] q;
		logic [FRAC_BITS-1:0] fu, fv;
		su = (split_u_q > 17'd65536) ? 65536 : split_u_q;
		sv = (split_v_q > 17'd65536) ? 65536 : split_v_q;
		fu = rq.coord_u[FRAC_BITS-1:0];
		fv = rq.coord_v[FRAC_BITS-1:0];
		du = magnitude(rq.du_di);
		a  = magnitude(rq.du_dj);
		if (a > du)
			du = a;
		dv = magnitude(rq.dv_di);
		a  = magnitude(rq.dv_dj);
		if (a > dv)
			dv = a;
		if (!box_mode_q || du == 0 || dv == 0) begin
			w.weight_a = ((longint'(fu) < su) == (longint'(fv) < sv)) ? W_ONE : '0;
			w.point_sampled = 1'b1;
			return w;
		end
		cu2 = 2 * longint'(fu);
		cv2 = 2 * longint'(fv);
		lu = low_span(cu2 + du, 2 * su) - low_span(cu2 - du, 2 * su);
		lv = low_span(cv2 + dv, 2 * sv) - low_span(cv2 - dv, 2 * sv);
		hu = 2 * du - lu;
		hv = 2 * dv - lv;
		num = 64'(lu) * 64'(lv) + 64'(hu) * 64'(hv);
		den = 64'(2 * du) * 64'(2 * dv);
		if (num >= den) begin
			q = W_ONE;
		end else begin
			r = num;
			q = '0;
			for (int k = 0; k < QB; k++) begin
				q = q << 1;
				if (r >= den - r) begin
					r = r - (den - r);
					q[0] = 1'b1;
				end else begin
					r = r + r;
				end
			end
		end
		w.weight_a = q;
		w.point_sampled = 1'b0;
		return w;
	endfunction

	always @(posedge clk) begin
		weight_t got, want;
		if (result.valid && result.ready) begin
			got.weight_a = result.weight_a;
			got.point_sampled = result.point_sampled;
			if (pending_weights.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %0d/%0b", got.weight_a, got.point_sampled);
			end else begin
				want = pending_weights.pop_front();
				if (got.weight_a !== want.weight_a ||
						got.point_sampled !== want.point_sampled) begin
					mismatches++;
					if (mismatches <= 10)
						$display("weight mismatch: expected %0d/%0b, got %0d/%0b",
							want.weight_a, want.point_sampled,
							got.weight_a, got.point_sampled);
				end
			end
		end
	end

	// result side: random hold-offs, one long stall on demand
	initial begin
		int n;
		result.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				n = 400;
				long_hold = 0;
			end else begin
				n = quiet ? 0 : $urandom_range(0, 13);
			end
			repeat (n) begin
				@(negedge clk);
				result.ready <= 1'b0;
			end
			@(negedge clk);
			result.ready <= 1'b1;
			do @(posedge clk); while (!(result.valid && result.ready));
		end
	end

	task automatic send_request(input request_t rq);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			@(negedge clk);
			sample.valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		sample.valid   = 1'b1;
		sample.coord_u = rq.coord_u;
		sample.coord_v = rq.coord_v;
		sample.du_di   = rq.du_di;
		sample.dv_di   = rq.dv_di;
		sample.du_dj   = rq.du_dj;
		sample.dv_dj   = rq.dv_dj;
		do @(posedge clk); while (!sample.ready);
		pending_weights.push_back(checker_weight(rq));
	endtask

	task automatic settle;
		@(negedge clk);
		sample.valid = 1'b0;
		while (pending_weights.size() != 0)
			@(negedge clk);
		repeat (DRAIN) @(negedge clk);
	endtask

	task automatic write_reg(input logic [IDXW-1:0] idx, input logic [SPW-1:0] data);
		settle();
		cfg_wen   = 1'b1;
		cfg_idx   = idx;
		cfg_wdata = data;
		case (idx)
			REG_SPLIT_U: split_u_q = data;
			REG_SPLIT_V: split_v_q = data;
			default:     box_mode_q = data[0];
		endcase
		@(negedge clk);
		cfg_wen = 1'b0;
	endtask

	function automatic logic [CW-1:0] rand_slope;
		logic [CW-1:0] m;
		case ($urandom_range(0, 7))
			0: m = '0;
			1: m = $urandom;
			2: m = 32'h8000_0000;
			3: m = 32'h7FFF_FFFF;
			4: m = $urandom_range(1, 1 << 20);
			5: m = $urandom_range(1, 1 << 17);
			default: m = $urandom_range(1, 1 << 14);
		endcase
		return $urandom_range(0, 1) ? -m : m;
	endfunction

	function automatic request_t rand_request;
		request_t rq;
		rq.coord_u = $urandom;
		rq.coord_v = $urandom;
		rq.du_di = rand_slope();
		rq.dv_di = rand_slope();
		rq.du_dj = rand_slope();
		rq.dv_dj = rand_slope();
		return rq;
	endfunction

	task automatic test_directed_box;
		request_t rq;
		logic [CW-1:0] coords[6] = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000,
			32'hFFFF_FFFF, 32'h0000_8000, 32'h0001_7FFF};
		foreach (coords[i]) begin
			rq = '{coords[i], coords[5 - i], 32'h100, 32'h0, 32'h0, 32'hFFFF_FF00};
			send_request(rq);
		end
		send_request('{32'h4000, 32'hC000, 32'h0, 32'h1000, 32'h0, 32'h0});
		send_request('{32'h4000, 32'hC000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h1});
		send_request('{32'h7FFF, 32'h8000, 32'h1, 32'h1, 32'h0, 32'h0});
		send_request('{32'hFFFF_8000, 32'h8000, 32'h0001_0000, 32'h0, 32'h0,
			32'hFFFF_0000});
		send_request('{32'h1234_5678, 32'h8765_4321, 32'h0002_0000, 32'h0000_0800,
			32'hFFF0_0000, 32'h0});
	endtask

	task automatic test_point_mode;
		write_reg(REG_AA_MODE, 17'd0);
		repeat (8) send_request(rand_request());
		send_request('{32'h0, 32'hFFFF, 32'h0, 32'h0, 32'h0, 32'h0});
		write_reg(REG_AA_MODE, 17'd1);
	endtask

	task automatic test_split_extremes;
		logic [SPW-1:0] splits[5] = '{17'd0, 17'd65536, 17'h1FFFF, 17'd1, 17'd65535};
		foreach (splits[i]) begin
			write_reg(REG_SPLIT_U, splits[i]);
			write_reg(REG_SPLIT_V, splits[4 - i]);
			repeat (20) send_request(rand_request());
		end
	endtask

	task automatic test_random;
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(REG_SPLIT_U, SPW'($urandom_range(0, 131071)));
			write_reg(REG_SPLIT_V, SPW'($urandom_range(0, 65536)));
			write_reg(REG_AA_MODE, (ph % 4 == 3) ? 17'd0 : 17'd1);
			quiet = (ph == 2);
			repeat (170) send_request(rand_request());
		end
		quiet = 0;
	endtask

	task automatic test_backpressure;
		write_reg(REG_SPLIT_U, 17'd32768);
		write_reg(REG_SPLIT_V, 17'd20000);
		write_reg(REG_AA_MODE, 17'd1);
		quiet = 1;
		long_hold = 1;
		repeat (80) send_request(rand_request());
		quiet = 0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		sample.valid = 1'b0;
		sample.coord_u = '0;
		sample.coord_v = '0;
		sample.du_di = '0;
		sample.dv_di = '0;
		sample.du_dj = '0;
		sample.dv_dj = '0;
		split_u_q = 17'd32768;
		split_v_q = 17'd32768;
		box_mode_q = 1'b1;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		test_directed_box();
		test_point_mode();
		test_split_extremes();
		test_backpressure();
		test_random();
		settle();
		if (mismatches == 0 && pending_weights.size() == 0)
			$display("checker_box_filter_weight regression: pass");
		else
			$display("checker_box_filter_weight regression: fail");
		$finish;
	end
endmodule
`default_nettype wire

>>> checker_box_filter_weight.f
rtl/core/cbfw_pkg.sv
rtl/core/cbfw_if.sv
rtl/core/cbfw_divider.sv
rtl/core/checker_box_filter_weight.sv
bench/tb_checker_box_filter_weight.sv
